[sv/heightfield_bilinear_sampler_defines.svh]
// Assertion macros for the heightfield bilinear sampler.
// Included by the top level; needs clk and rst_n in the including scope.
`ifndef HEIGHTFIELD_BILINEAR_SAMPLER_DEFINES_SVH
`define HEIGHTFIELD_BILINEAR_SAMPLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heightfield sampler check failed");
`define HBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heightfield sampler check failed");
`else
`define HBS_ASSERT_NOW(lbl, ante, cons)
`define HBS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[sv/hbs_pkg.sv]
// Shared types and constants of the heightfield bilinear sampler.
// No dependencies.
`default_nettype none

package hbs_pkg;

  localparam int COORD_W         = 32;
  localparam int CODE_W          = 16;
  localparam int INDEX_W         = 16;
  localparam int SCALE_W         = 24;
  localparam int DIM_W           = 9;
  localparam int OUT_W           = 32;
  localparam int SCALE_FRAC_BITS = 16;
  localparam int NUM_STAGES      = 7;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_X          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Z          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_SAMPLES  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SAMPLES = 3'd5;

  // per-stage load enables and valid bits
  typedef struct packed {
    logic [NUM_STAGES:1] adv;
    logic [NUM_STAGES:1] vld;
  } hbs_pipe_t;

endpackage

`default_nettype wire

[sv/hbs_map.sv]
// Maps one world coordinate to a grid cell and fraction (stages 1 to 3).
// Uses hbs_pkg.
`default_nettype none

module hbs_map #(
  parameter int GRID_SIDE_MAX   = 256,
  parameter int COORD_FRAC_BITS = 16,
  localparam int CELL_W = (GRID_SIDE_MAX > 2) ? $clog2(GRID_SIDE_MAX) : 1,
  localparam int SIDE_W = $clog2(GRID_SIDE_MAX + 1)
) (
  input  wire logic                             clk,
  input  wire hbs_pkg::hbs_pipe_t               pipe,
  input  wire logic signed [hbs_pkg::COORD_W-1:0] coord,
  input  wire logic signed [hbs_pkg::COORD_W-1:0] minv,
  input  wire logic [hbs_pkg::SCALE_W-1:0]      scale,
  input  wire logic [SIDE_W-1:0]                side,
  output logic                                  ok,
  output logic [CELL_W-1:0]                     cell_idx,
  output logic [COORD_FRAC_BITS-1:0]            frac
);
  import hbs_pkg::*;

  localparam int F       = COORD_FRAC_BITS;
  localparam int PROD_W  = COORD_W + SCALE_W;
  localparam int WHOLE_W = PROD_W - SCALE_FRAC_BITS - F;
  localparam int CMP_W   = ((WHOLE_W > SIDE_W) ? WHOLE_W : SIDE_W) + 1;

  logic [COORD_W:0]     d1_r;
  logic [PROD_W-1:0]    prod2_r;
  logic                 neg2_r;
  logic                 ok3_r;
  logic [CELL_W-1:0]    cell3_r;
  logic [F-1:0]         frac3_r;
  logic [WHOLE_W-1:0]   whole;
  logic                 ok3_nxt;

  always_ff @(posedge clk) begin
    if (pipe.adv[1]) begin
      d1_r <= {coord[COORD_W-1], coord} - {minv[COORD_W-1], minv};
    end
  end

  // a negative offset times a zero scale is zero, not negative
  always_ff @(posedge clk) begin
    if (pipe.adv[2]) begin
      prod2_r <= PROD_W'(d1_r[COORD_W-1:0]) * PROD_W'(scale);
      neg2_r  <= d1_r[COORD_W] && (scale != '0);
    end
  end

  always_comb begin
    whole   = prod2_r[PROD_W-1:SCALE_FRAC_BITS+F];
    ok3_nxt = !neg2_r && ((CMP_W'(whole) + CMP_W'(1)) < CMP_W'(side));
  end

  always_ff @(posedge clk) begin
    if (pipe.adv[3]) begin
      ok3_r   <= ok3_nxt;
      cell3_r <= whole[CELL_W-1:0];
      frac3_r <= prod2_r[SCALE_FRAC_BITS+F-1:SCALE_FRAC_BITS];
    end
  end

  assign ok       = ok3_r;
  assign cell_idx = cell3_r;
  assign frac     = frac3_r;

endmodule

`default_nettype wire

[sv/hbs_grid.sv]
// Height grid store and quad fetch (stages 4 and 5): two copies of the grid,
// each read at two addresses per cycle. Uses hbs_pkg.
`default_nettype none

module hbs_grid #(
  parameter int GRID_SIDE_MAX   = 256,
  parameter int COORD_FRAC_BITS = 16,
  localparam int CELL_W = (GRID_SIDE_MAX > 2) ? $clog2(GRID_SIDE_MAX) : 1,
  localparam int SIDE_W = $clog2(GRID_SIDE_MAX + 1)
) (
  input  wire logic                          clk,
  input  wire hbs_pkg::hbs_pipe_t            pipe,
  input  wire logic [SIDE_W-1:0]             side,
  input  wire logic                          op,
  input  wire logic [hbs_pkg::INDEX_W-1:0]   idx,
  input  wire logic [hbs_pkg::CODE_W-1:0]    code,
  input  wire logic                          ok_x,
  input  wire logic                          ok_z,
  input  wire logic [CELL_W-1:0]             cell_x,
  input  wire logic [CELL_W-1:0]             cell_z,
  input  wire logic [COORD_FRAC_BITS-1:0]    frac_x,
  input  wire logic [COORD_FRAC_BITS-1:0]    frac_z,
  output logic                               qry,
  output logic                               inr,
  output logic [COORD_FRAC_BITS-1:0]         tx,
  output logic [COORD_FRAC_BITS-1:0]         tz,
  output logic [hbs_pkg::CODE_W-1:0]         q00,
  output logic [hbs_pkg::CODE_W-1:0]         q01,
  output logic [hbs_pkg::CODE_W-1:0]         q10,
  output logic [hbs_pkg::CODE_W-1:0]         q11
);
  import hbs_pkg::*;

  localparam int F      = COORD_FRAC_BITS;
  localparam int DEPTH  = GRID_SIDE_MAX * GRID_SIDE_MAX;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = CELL_W + SIDE_W;

  logic [CODE_W-1:0] mem_near [DEPTH];
  logic [CODE_W-1:0] mem_far  [DEPTH];

  logic [ROW_W-1:0]  row_base;
  logic [ADDR_W-1:0] a4_nxt;
  logic [ADDR_W-1:0] a4_r;
  logic              qry4_r, inr4_r, wr4_r;
  logic [ADDR_W-1:0] wa4_r;
  logic [CODE_W-1:0] wd4_r;
  logic [F-1:0]      tx4_r, tz4_r;
  logic [ADDR_W-1:0] ra0, ra1, ra2, ra3;
  logic              qry5_r, inr5_r;
  logic [F-1:0]      tx5_r, tz5_r;
  logic [CODE_W-1:0] q00_r, q01_r, q10_r, q11_r;

  always_comb begin
    row_base = ROW_W'(cell_z) * ROW_W'(side);
    a4_nxt   = ADDR_W'(cell_x) + ADDR_W'(row_base);
  end

  always_ff @(posedge clk) begin
    if (pipe.adv[4]) begin
      a4_r   <= a4_nxt;
      qry4_r <= (op == OP_QUERY);
      inr4_r <= ok_x && ok_z;
      wr4_r  <= (op == OP_WRITE) && (32'(idx) < 32'(DEPTH));
      wa4_r  <= ADDR_W'(idx);
      wd4_r  <= code;
      tx4_r  <= frac_x;
      tz4_r  <= frac_z;
    end
  end

  always_comb begin
    ra0 = a4_r;
    ra1 = a4_r + ADDR_W'(1);
    ra2 = a4_r + ADDR_W'(side);
    ra3 = a4_r + ADDR_W'(side) + ADDR_W'(1);
  end

  // writes and reads both happen as the item leaves stage 4, so order holds
  always_ff @(posedge clk) begin
    if (pipe.adv[5] && pipe.vld[4] && wr4_r) begin
      mem_near[wa4_r] <= wd4_r;
    end
    if (pipe.adv[5] && qry4_r && inr4_r) begin
      q00_r <= mem_near[ra0];
      q01_r <= mem_near[ra1];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.adv[5] && pipe.vld[4] && wr4_r) begin
      mem_far[wa4_r] <= wd4_r;
    end
    if (pipe.adv[5] && qry4_r && inr4_r) begin
      q10_r <= mem_far[ra2];
      q11_r <= mem_far[ra3];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.adv[5]) begin
      qry5_r <= qry4_r;
      inr5_r <= inr4_r;
      tx5_r  <= tx4_r;
      tz5_r  <= tz4_r;
    end
  end

  assign qry = qry5_r;
  assign inr = inr5_r;
  assign tx  = tx5_r;
  assign tz  = tz5_r;
  assign q00 = q00_r;
  assign q01 = q01_r;
  assign q10 = q10_r;
  assign q11 = q11_r;

endmodule

`default_nettype wire

[sv/hbs_lerp.sv]
// Bilinear blend: X lerp in stage 6, Z lerp and output register in stage 7.
// Uses hbs_pkg.
`default_nettype none

module hbs_lerp #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire hbs_pkg::hbs_pipe_t          pipe,
  input  wire logic                        inr,
  input  wire logic [COORD_FRAC_BITS-1:0]  tx,
  input  wire logic [COORD_FRAC_BITS-1:0]  tz,
  input  wire logic [hbs_pkg::CODE_W-1:0]  q00,
  input  wire logic [hbs_pkg::CODE_W-1:0]  q01,
  input  wire logic [hbs_pkg::CODE_W-1:0]  q10,
  input  wire logic [hbs_pkg::CODE_W-1:0]  q11,
  output logic                             in_range,
  output logic [hbs_pkg::OUT_W-1:0]        height_code
);
  import hbs_pkg::*;

  localparam int F     = COORD_FRAC_BITS;
  localparam int WT_W  = F + 1;
  localparam int L_W   = CODE_W + F;
  localparam int PW1   = CODE_W + WT_W;
  localparam int PW2   = L_W + WT_W;
  localparam int SHIFT = 2 * F - 16;
  localparam logic [WT_W-1:0] ONE = WT_W'(1) << F;

  logic [WT_W-1:0]  wx, wz;
  logic [PW1-1:0]   l0_sum, l1_sum;
  logic [L_W-1:0]   l0_r, l1_r;
  logic [F-1:0]     tz6_r;
  logic             inr6_r;
  logic [PW2-1:0]   v_sum;
  logic             inr7_r;
  logic [OUT_W-1:0] height7_r;

  always_comb begin
    wx     = ONE - WT_W'(tx);
    l0_sum = PW1'(q00) * PW1'(wx) + PW1'(q01) * PW1'(tx);
    l1_sum = PW1'(q10) * PW1'(wx) + PW1'(q11) * PW1'(tx);
  end

  always_ff @(posedge clk) begin
    if (pipe.adv[6]) begin
      l0_r   <= l0_sum[L_W-1:0];
      l1_r   <= l1_sum[L_W-1:0];
      tz6_r  <= tz;
      inr6_r <= inr;
    end
  end

  always_comb begin
    wz    = ONE - WT_W'(tz6_r);
    v_sum = PW2'(l0_r) * PW2'(wz) + PW2'(l1_r) * PW2'(tz6_r);
  end

  always_ff @(posedge clk) begin
    if (pipe.adv[7]) begin
      inr7_r    <= inr6_r;
      height7_r <= inr6_r ? v_sum[SHIFT+OUT_W-1:SHIFT] : '0;
    end
  end

  assign in_range    = inr7_r;
  assign height_code = height7_r;

endmodule

`default_nettype wire

[sv/heightfield_bilinear_sampler.sv]
// Heightfield bilinear sampler: grid store, coordinate mapping and blend.
// Uses hbs_pkg, hbs_map, hbs_grid, hbs_lerp and the defines header.
//
// Input channel (in_valid/in_stall): operation 0 writes sample_code at
// sample_index into the grid and gives no result; operation 1 queries the
// height at (query_x, query_z) and gives one result on the out_ channel.
// Configuration is written through cfg_write_en/cfg_index/cfg_data while idle.
// Seven register stages; a query moves from stage 1 to stage 7 and is shown
// on out_valid from stage 7. One item is accepted per cycle while in_stall
// is low. The grid is held in two copies, each read at two addresses a cycle,
// so all four neighbors of a query come from one memory stage. Writes and
// reads share that stage, so a query always sees every write accepted before
// it. Reset clears the pipeline valid bits and returns the configuration
// registers to their defaults; grid contents are undefined until written.
// When out_stall holds a result, stages behind it keep filling empty slots
// and in_stall rises only once every stage holds an item.
`default_nettype none

`include "heightfield_bilinear_sampler_defines.svh"

module heightfield_bilinear_sampler #(
  parameter int GRID_SIDE_MAX   = 256,
  parameter int COORD_FRAC_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_write_en,
  input  wire logic [hbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [hbs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_operation,
  input  wire logic [hbs_pkg::INDEX_W-1:0]         in_sample_index,
  input  wire logic [hbs_pkg::CODE_W-1:0]          in_sample_code,
  input  wire logic signed [hbs_pkg::COORD_W-1:0]  in_query_x,
  input  wire logic signed [hbs_pkg::COORD_W-1:0]  in_query_z,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_in_range,
  output logic [hbs_pkg::OUT_W-1:0]                out_height_code
);
  import hbs_pkg::*;

  localparam int CELL_W = (GRID_SIDE_MAX > 2) ? $clog2(GRID_SIDE_MAX) : 1;
  localparam int SIDE_W = $clog2(GRID_SIDE_MAX + 1);
  localparam int F      = COORD_FRAC_BITS;

  typedef struct packed {
    logic               op;
    logic [INDEX_W-1:0] idx;
    logic [CODE_W-1:0]  code;
  } meta_t;

  logic signed [COORD_W-1:0] min_x_r, min_z_r;
  logic [SCALE_W-1:0]        scale_x_r, scale_z_r;
  logic [DIM_W-1:0]          width_r, height_r;
  logic [SIDE_W-1:0]         side_x, side_z;

  logic [NUM_STAGES:1] v_r, v_nxt, adv;
  hbs_pipe_t           pipe;
  meta_t               meta_r [1:3];

  logic              ok_x, ok_z;
  logic [CELL_W-1:0] cell_x, cell_z;
  logic [F-1:0]      frac_x, frac_z;
  logic              qry5, inr5;
  logic [F-1:0]      tx5, tz5;
  logic [CODE_W-1:0] q00, q01, q10, q11;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r   <= '0;
      min_z_r   <= '0;
      scale_x_r <= SCALE_W'(65536);
      scale_z_r <= SCALE_W'(65536);
      width_r   <= DIM_W'(256);
      height_r  <= DIM_W'(256);
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_MIN_X:          min_x_r   <= cfg_data;
        REG_MIN_Z:          min_z_r   <= cfg_data;
        REG_SCALE_X:        scale_x_r <= cfg_data[SCALE_W-1:0];
        REG_SCALE_Z:        scale_z_r <= cfg_data[SCALE_W-1:0];
        REG_WIDTH_SAMPLES:  width_r   <= cfg_data[DIM_W-1:0];
        REG_HEIGHT_SAMPLES: height_r  <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    side_x = (int'(width_r) > GRID_SIDE_MAX) ? SIDE_W'(GRID_SIDE_MAX) : SIDE_W'(width_r);
    side_z = (int'(height_r) > GRID_SIDE_MAX) ? SIDE_W'(GRID_SIDE_MAX) : SIDE_W'(height_r);
  end

  // a stage loads when it is empty or the stage ahead of it moves
  always_comb begin
    adv[NUM_STAGES] = !v_r[NUM_STAGES] || !out_stall;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
    v_nxt = v_r;
    for (int k = 1; k <= NUM_STAGES; k++) begin
      if (adv[k]) begin
        if (k == 1) begin
          v_nxt[k] = in_valid;
        end else if (k == 6) begin
          v_nxt[k] = v_r[k-1] && qry5;  // writes end at the memory stage
        end else begin
          v_nxt[k] = v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      meta_r[1] <= '{op: in_operation, idx: in_sample_index, code: in_sample_code};
    end
    if (adv[2]) begin
      meta_r[2] <= meta_r[1];
    end
    if (adv[3]) begin
      meta_r[3] <= meta_r[2];
    end
  end

  assign pipe.adv = adv;
  assign pipe.vld = v_r;
  assign in_stall = !adv[1];

  hbs_map #(
    .GRID_SIDE_MAX   (GRID_SIDE_MAX),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_map_x (
    .clk      (clk),
    .pipe     (pipe),
    .coord    (in_query_x),
    .minv     (min_x_r),
    .scale    (scale_x_r),
    .side     (side_x),
    .ok       (ok_x),
    .cell_idx (cell_x),
    .frac     (frac_x)
  );

  hbs_map #(
    .GRID_SIDE_MAX   (GRID_SIDE_MAX),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_map_z (
    .clk      (clk),
    .pipe     (pipe),
    .coord    (in_query_z),
    .minv     (min_z_r),
    .scale    (scale_z_r),
    .side     (side_z),
    .ok       (ok_z),
    .cell_idx (cell_z),
    .frac     (frac_z)
  );

  hbs_grid #(
    .GRID_SIDE_MAX   (GRID_SIDE_MAX),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_grid (
    .clk    (clk),
    .pipe   (pipe),
    .side   (side_x),
    .op     (meta_r[3].op),
    .idx    (meta_r[3].idx),
    .code   (meta_r[3].code),
    .ok_x   (ok_x),
    .ok_z   (ok_z),
    .cell_x (cell_x),
    .cell_z (cell_z),
    .frac_x (frac_x),
    .frac_z (frac_z),
    .qry    (qry5),
    .inr    (inr5),
    .tx     (tx5),
    .tz     (tz5),
    .q00    (q00),
    .q01    (q01),
    .q10    (q10),
    .q11    (q11)
  );

  hbs_lerp #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_lerp (
    .clk         (clk),
    .pipe        (pipe),
    .inr         (inr5),
    .tx          (tx5),
    .tz          (tz5),
    .q00         (q00),
    .q01         (q01),
    .q10         (q10),
    .q11         (q11),
    .in_range    (out_in_range),
    .height_code (out_height_code)
  );

  assign out_valid = v_r[NUM_STAGES];

  `HBS_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid && out_stall && (&v_r))
  `HBS_ASSERT_NEXT(a_accept_enters_pipe, in_valid && !in_stall, v_r[1])
  `HBS_ASSERT_NOW(a_out_of_range_zero, out_valid && !out_in_range, out_height_code == '0)
  `HBS_ASSERT_NOW(a_height_max, out_valid, out_height_code <= 32'hFFFF0000)

endmodule

`default_nettype wire
